// ===== rtl/core/qema_pkg.sv =====
package qema_pkg;

    // Default values for the top-level parameters.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 6;

    // Field widths of the beats and of the configuration port.
    localparam int CMD_W      = 2;
    localparam int Q_W        = 16;
    localparam int YAW_W      = 15;
    localparam int PITCH_W    = 14;
    localparam int ROLL_W     = 15;
    localparam int THR_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // CORDIC vector width and angle accumulator width (1/65536 degree).
    localparam int XW = 38;
    localparam int ZW = 27;
    localparam int ATAN_W = 22;

    // Event kinds.
    localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROTV  = 2'd1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOCK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT   = 2'd2;

    // Register reset values.
    localparam logic [THR_W-1:0] SHOCK_RST = 15'd512;
    localparam logic [THR_W-1:0] TILT_RST  = 15'd640;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic [ATAN_W-1:0] atan_step(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/quaternion_euler_motion_alerts.sv =====
// Channel   Valid        Stall        Payload
// input     i_in_valid   o_in_stall   i_cmd, i_quat_*, i_accel_*
// output    o_out_valid  i_out_stall  o_out_yaw_angle .. o_out_tilt_flag
// config    i_cfg_we     (none)       i_cfg_idx, i_cfg_data
//
// A rotation-vector beat runs ten products on the shared multiplier, a 29-step square
// root and three passes through the one CORDIC unit, done one after the other, and an
// acceleration beat runs four products. Other beats, and all beats while the sensor
// register is clear, go straight to the finishing state.
// Reset is synchronous and active low; it restores the register defaults and
// forgets the previous orientation. The input stalls while a beat is at work;
// a finished result waits in the output register while the output stalls.
module quaternion_euler_motion_alerts #(
    parameter int CORDIC_STEPS    = qema_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = qema_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [qema_pkg::CMD_W-1:0]             i_cmd,
    input  logic signed [qema_pkg::Q_W-1:0]        i_quat_real,
    input  logic signed [qema_pkg::Q_W-1:0]        i_quat_i,
    input  logic signed [qema_pkg::Q_W-1:0]        i_quat_j,
    input  logic signed [qema_pkg::Q_W-1:0]        i_quat_k,
    input  logic signed [qema_pkg::Q_W-1:0]        i_accel_x,
    input  logic signed [qema_pkg::Q_W-1:0]        i_accel_y,
    input  logic signed [qema_pkg::Q_W-1:0]        i_accel_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [qema_pkg::YAW_W-1:0]             o_out_yaw_angle,
    output logic signed [qema_pkg::PITCH_W-1:0]    o_out_pitch_angle,
    output logic signed [qema_pkg::ROLL_W-1:0]     o_out_roll_angle,
    output logic                                   o_out_angles_valid,
    output logic                                   o_out_shock_flag,
    output logic                                   o_out_tilt_flag,
    input  logic                                   i_cfg_we,
    input  logic [qema_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [qema_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import qema_pkg::*;

    localparam int UW = ANGLE_FRAC_BITS + 10;
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int CW = (UW + 2 > 17) ? UW + 2 : 17;
    localparam int AW = 34;
    localparam int MW = 30;
    localparam int SQ_STEPS = 29;
    localparam logic signed [UW-1:0] FULL_TURN = UW'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ZW:0]   ROUND_HALF = (ZW+1)'(1) <<< (SH - 1);
    localparam logic signed [35:0]   Q28_POS = 36'sd1 <<< 28;
    localparam logic signed [35:0]   Q28_NEG = -(36'sd1 <<< 28);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_FORM, S_SQ, S_SQLOAD, S_SQRT,
        S_CORD_START, S_CORD_WAIT, S_POST, S_FIN
    } t_state;

    t_state                r_state;
    logic                  r_sensor;
    logic [THR_W-1:0]      r_shock_thr;
    logic [THR_W-1:0]      r_tilt_thr;
    logic                  r_is_rot;
    logic signed [Q_W-1:0] r_op [4];
    logic [3:0]            r_cnt;
    logic signed [AW-1:0]  r_acc [5];
    logic signed [2*MW-1:0] r_prod;
    logic signed [XW-1:0]  r_yn, r_yd, r_rn, r_rd;
    logic signed [MW-1:0]  r_s;
    logic [57:0]           r_sq_v;
    logic [31:0]           r_rem;
    logic [28:0]           r_root;
    logic [4:0]            r_sq_cnt;
    logic [1:0]            r_ang;
    logic signed [UW-1:0]  r_yaw, r_pitch, r_roll;
    logic signed [UW-1:0]  r_last_pitch, r_last_roll;
    logic                  r_last_valid;
    logic                  r_angv, r_shock, r_tilt;

    logic                  in_acc;
    logic [1:0]            idx_a, idx_b;
    logic                  use_thr;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic [3:0]            nprod;
    logic [3:0]            prev;
    logic [2:0]            dest;
    logic                  sub;
    logic signed [35:0]    s2;
    logic [33:0]           rem2;
    logic [33:0]           trial;
    logic                  cord_start;
    logic signed [XW-1:0]  cord_x, cord_y;
    logic                  cord_done;
    logic signed [ZW-1:0]  cord_z;
    logic signed [ZW:0]    z_rnd;
    logic signed [UW-1:0]  n_unit;
    logic signed [CW-1:0]  dp, dr;
    logic [CW-1:0]         adp, adr;
    logic                  n_tilt;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Operand schedule of the shared multiplier.
    always_comb begin
        idx_a   = 2'd0;
        idx_b   = 2'd0;
        use_thr = 1'b0;
        if (r_is_rot) begin
            case (r_cnt)
                4'd0:    begin idx_a = 2'd0; idx_b = 2'd3; end
                4'd1:    begin idx_a = 2'd1; idx_b = 2'd2; end
                4'd2:    begin idx_a = 2'd2; idx_b = 2'd2; end
                4'd3:    begin idx_a = 2'd3; idx_b = 2'd3; end
                4'd4:    begin idx_a = 2'd0; idx_b = 2'd1; end
                4'd5:    begin idx_a = 2'd2; idx_b = 2'd3; end
                4'd6:    begin idx_a = 2'd1; idx_b = 2'd1; end
                4'd7:    begin idx_a = 2'd2; idx_b = 2'd2; end
                4'd8:    begin idx_a = 2'd0; idx_b = 2'd2; end
                default: begin idx_a = 2'd3; idx_b = 2'd1; end
            endcase
        end else begin
            case (r_cnt)
                4'd0:    begin idx_a = 2'd0; idx_b = 2'd0; end
                4'd1:    begin idx_a = 2'd1; idx_b = 2'd1; end
                4'd2:    begin idx_a = 2'd2; idx_b = 2'd2; end
                default: use_thr = 1'b1;
            endcase
        end
        if (r_state == S_SQ) begin
            mul_a = r_s;
            mul_b = r_s;
        end else if (use_thr) begin
            mul_a = MW'($signed({1'b0, r_shock_thr}));
            mul_b = MW'($signed({1'b0, r_shock_thr}));
        end else begin
            mul_a = MW'(r_op[idx_a]);
            mul_b = MW'(r_op[idx_b]);
        end
    end

    // Accumulator that takes the product issued in the previous cycle.
    always_comb begin
        nprod = r_is_rot ? 4'd10 : 4'd4;
        prev  = r_cnt - 4'd1;
        if (r_is_rot) begin
            dest = prev[3:1];
            sub  = (prev == 4'd9);
        end else begin
            dest = (prev == 4'd3) ? 3'd1 : 3'd0;
            sub  = 1'b0;
        end
        s2 = 36'(r_acc[4]) <<< 1;
    end

    // One step of the digit-by-digit square root.
    always_comb begin
        rem2  = {r_rem, r_sq_v[57:56]};
        trial = 34'({r_root, 2'b01});
    end

    // CORDIC operand select and rounding of its angle to the output unit.
    always_comb begin
        cord_start = (r_state == S_CORD_START);
        case (r_ang)
            2'd0:    begin cord_x = r_yd; cord_y = r_yn; end
            2'd1:    begin cord_x = XW'($signed({1'b0, r_root})); cord_y = XW'(r_s); end
            default: begin cord_x = r_rd; cord_y = r_rn; end
        endcase
        z_rnd  = (ZW+1)'(cord_z) + ROUND_HALF;
        n_unit = UW'(z_rnd >>> SH);
    end

    // Tilt test against the previous orientation.
    always_comb begin
        dp     = CW'(r_pitch) - CW'(r_last_pitch);
        dr     = CW'(r_roll) - CW'(r_last_roll);
        adp    = (dp < 0) ? CW'(-dp) : CW'(dp);
        adr    = (dr < 0) ? CW'(-dr) : CW'(dr);
        n_tilt = r_last_valid && ((adp > CW'(r_tilt_thr)) || (adr > CW'(r_tilt_thr)));
    end

    qema_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (cord_x),
        .i_y     (cord_y),
        .o_done  (cord_done),
        .o_angle (cord_z)
    );

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor    <= 1'b0;
            r_shock_thr <= SHOCK_RST;
            r_tilt_thr  <= TILT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSOR: r_sensor    <= i_cfg_data[0];
                CFG_SHOCK:  r_shock_thr <= i_cfg_data[THR_W-1:0];
                CFG_TILT:   r_tilt_thr  <= i_cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequencer, orientation state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_valid <= 1'b0;
            r_last_pitch <= '0;
            r_last_roll  <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            // The finishing state reloads the output register itself.
            if (o_out_valid && !i_out_stall && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_yaw   <= '0;
                        r_pitch <= '0;
                        r_roll  <= '0;
                        r_angv  <= 1'b0;
                        r_shock <= 1'b0;
                        r_tilt  <= 1'b0;
                        r_cnt   <= '0;
                        for (int k = 0; k < 5; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_is_rot <= (i_cmd == CMD_ROTV);
                        if (i_cmd == CMD_ROTV) begin
                            r_op[0] <= i_quat_real;
                            r_op[1] <= i_quat_i;
                            r_op[2] <= i_quat_j;
                            r_op[3] <= i_quat_k;
                        end else begin
                            r_op[0] <= i_accel_x;
                            r_op[1] <= i_accel_y;
                            r_op[2] <= i_accel_z;
                            r_op[3] <= '0;
                        end
                        if (r_sensor && (i_cmd == CMD_ROTV || i_cmd == CMD_ACCEL)) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt != 4'd0) begin
                        for (int k = 0; k < 5; k++) begin
                            if (dest == 3'(k)) begin
                                if (sub) begin
                                    r_acc[k] <= r_acc[k] - AW'(r_prod);
                                end else begin
                                    r_acc[k] <= r_acc[k] + AW'(r_prod);
                                end
                            end
                        end
                    end
                    if (r_cnt == nprod) begin
                        r_state <= S_FORM;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_FORM: begin
                    if (r_is_rot) begin
                        r_yn <= XW'(r_acc[0]) <<< 1;
                        r_yd <= (XW'(1) <<< 28) - (XW'(r_acc[1]) <<< 1);
                        r_rn <= XW'(r_acc[2]) <<< 1;
                        r_rd <= (XW'(1) <<< 28) - (XW'(r_acc[3]) <<< 1);
                        if (s2 > Q28_POS) begin
                            r_s <= MW'(Q28_POS);
                        end else if (s2 < Q28_NEG) begin
                            r_s <= MW'(Q28_NEG);
                        end else begin
                            r_s <= MW'(s2);
                        end
                        r_state <= S_SQ;
                    end else begin
                        r_shock <= (r_acc[0] > r_acc[1]);
                        r_state <= S_FIN;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQLOAD;
                end
                S_SQLOAD: begin
                    r_sq_v   <= 58'(((2*MW)'(1) <<< 56) - r_prod);
                    r_rem    <= '0;
                    r_root   <= '0;
                    r_sq_cnt <= '0;
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    if (rem2 >= trial) begin
                        r_rem  <= 32'(rem2 - trial);
                        r_root <= {r_root[27:0], 1'b1};
                    end else begin
                        r_rem  <= 32'(rem2);
                        r_root <= {r_root[27:0], 1'b0};
                    end
                    r_sq_v <= {r_sq_v[55:0], 2'b00};
                    if (r_sq_cnt == 5'(SQ_STEPS - 1)) begin
                        r_ang   <= 2'd0;
                        r_state <= S_CORD_START;
                    end else begin
                        r_sq_cnt <= r_sq_cnt + 5'd1;
                    end
                end
                S_CORD_START: begin
                    r_state <= S_CORD_WAIT;
                end
                S_CORD_WAIT: begin
                    if (cord_done) begin
                        case (r_ang)
                            2'd0: begin
                                r_yaw <= (n_unit < 0) ? n_unit + FULL_TURN : n_unit;
                            end
                            2'd1:    r_pitch <= n_unit;
                            default: r_roll  <= n_unit;
                        endcase
                        if (r_ang == 2'd2) begin
                            r_state <= S_POST;
                        end else begin
                            r_ang   <= r_ang + 2'd1;
                            r_state <= S_CORD_START;
                        end
                    end
                end
                S_POST: begin
                    r_tilt       <= n_tilt;
                    r_angv       <= 1'b1;
                    r_last_pitch <= r_pitch;
                    r_last_roll  <= r_roll;
                    r_last_valid <= 1'b1;
                    r_state      <= S_FIN;
                end
                S_FIN: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid        <= 1'b1;
                        o_out_yaw_angle    <= YAW_W'(r_yaw);
                        o_out_pitch_angle  <= PITCH_W'(r_pitch);
                        o_out_roll_angle   <= ROLL_W'(r_roll);
                        o_out_angles_valid <= r_angv;
                        o_out_shock_flag   <= r_shock;
                        o_out_tilt_flag    <= r_tilt;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/qema_cordic.sv =====
module qema_cordic #(
    parameter int STEPS = qema_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [qema_pkg::XW-1:0]    i_x,
    input  logic signed [qema_pkg::XW-1:0]    i_y,
    output logic                              o_done,
    output logic signed [qema_pkg::ZW-1:0]    o_angle
);
    import qema_pkg::*;

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);

    logic                 r_busy;
    logic [IW-1:0]        r_i;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step_ang;

    // Floor shifts and the angle of the current micro-rotation.
    always_comb begin
        xs       = r_x >>> r_i;
        ys       = r_y >>> r_i;
        step_ang = ZW'($signed({1'b0, atan_step(5'(r_i))}));
    end

    // Vectoring iterations, one per cycle, after folding the left half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? HALF_TURN : -HALF_TURN;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + step_ang;
                end else if (r_y < 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - step_ang;
                end
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_angle = r_z;

endmodule

// ===== rtl/core/qema_checker.sv =====
module qema_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [qema_pkg::YAW_W-1:0]          o_out_yaw_angle,
    input logic signed [qema_pkg::PITCH_W-1:0] o_out_pitch_angle,
    input logic signed [qema_pkg::ROLL_W-1:0]  o_out_roll_angle,
    input logic                                o_out_angles_valid,
    input logic                                o_out_shock_flag,
    input logic                                o_out_tilt_flag
);

    // A result beat that is held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // Angles and shock never come from the same event.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_angles_valid) |-> !o_out_shock_flag)
        else $error("shock flag set on an orientation result");

    // Results that are not orientations carry no angles and no tilt.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_angles_valid) |->
        (o_out_yaw_angle == '0 && o_out_pitch_angle == '0 &&
         o_out_roll_angle == '0 && !o_out_tilt_flag))
        else $error("angle fields set on a non-orientation result");

    // An accepted input beat keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a beat");

endmodule

bind quaternion_euler_motion_alerts qema_checker u_qema_checker (.*);
